// ===== hw/rtl/jss_pkg.sv =====
// Shared types and constants for the JSON structural scanner.
// Used by json_structural_scanner and its checker. No dependencies.
package jss_pkg;

    // Nesting limit; the depth counter is eight bits wide
    localparam int MAX_DEPTH     = 255;
    localparam int DEPTH_CAP_INT = (MAX_DEPTH < 255) ? MAX_DEPTH : 255;
    localparam logic [7:0] DEPTH_CAP = DEPTH_CAP_INT[7:0];

    // Characters the scanner reacts to
    localparam logic [7:0] CH_LBRACE    = 8'h7B; // {
    localparam logic [7:0] CH_RBRACE    = 8'h7D; // }
    localparam logic [7:0] CH_LBRACKET  = 8'h5B; // [
    localparam logic [7:0] CH_RBRACKET  = 8'h5D; // ]
    localparam logic [7:0] CH_QUOTE     = 8'h22; // "
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_LOWER_T   = 8'h74;
    localparam logic [7:0] CH_UPPER_T   = 8'h54;
    localparam logic [7:0] CH_LOWER_F   = 8'h66;
    localparam logic [7:0] CH_UPPER_F   = 8'h46;
    localparam logic [7:0] CH_LOWER_E   = 8'h65;
    localparam logic [7:0] CH_UPPER_E   = 8'h45;
    localparam logic [7:0] CH_LOWER_R   = 8'h72;
    localparam logic [7:0] CH_LOWER_U   = 8'h75;
    localparam logic [7:0] CH_LOWER_A   = 8'h61;
    localparam logic [7:0] CH_LOWER_L   = 8'h6C;
    localparam logic [7:0] CH_LOWER_S   = 8'h73;
    localparam logic [7:0] CH_DIGIT_0   = 8'h30;
    localparam logic [7:0] CH_DIGIT_9   = 8'h39;
    localparam logic [7:0] CH_MINUS     = 8'h2D;
    localparam logic [7:0] CH_PLUS      = 8'h2B;
    localparam logic [7:0] CH_POINT     = 8'h2E;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_RETURN    = 8'h0D;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CASE_FOLD    = 8'h20;

    localparam logic [2:0] TRUE_LEN  = 3'd3;
    localparam logic [2:0] FALSE_LEN = 3'd4;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_START    = 3'd1,
        EV_END      = 3'd2,
        EV_CLOSE    = 3'd3,
        EV_UNTERM   = 3'd4,
        EV_BAD_BOOL = 3'd5,
        EV_DEPTH    = 3'd6
    } event_kind_t;

    typedef enum logic [2:0] {
        K_OBJECT  = 3'd0,
        K_ARRAY   = 3'd1,
        K_STRING  = 3'd2,
        K_BOOL    = 3'd3,
        K_NUMBER  = 3'd4,
        K_UNKNOWN = 3'd5
    } value_kind_t;

    typedef enum logic [4:0] {
        MODE_BETWEEN = 5'b00001,
        MODE_STRING  = 5'b00010,
        MODE_TRUE    = 5'b00100,
        MODE_FALSE   = 5'b01000,
        MODE_NUMBER  = 5'b10000
    } scan_mode_t;

endpackage

// ===== hw/rtl/json_structural_scanner.sv =====
// JSON structural scanner: one byte in, one structural result out.
// Depends on jss_pkg.
//
//   channel   dir  width  contents (low bit first)
//   s_*       in   8      in_byte
//   m_*       out  16     event_kind[2:0], value_kind[5:3], nest_level[13:6],
//                         bool_result[14], zero[15]
//
// One byte per clock sustained while m_tready holds high; each request is
// registered in the input register and then in the result register, with the
// scan state update computed combinationally between the two.
// rst_n clears both stage valids and returns the scanner to between values.
// A stalled output holds its result; the input register still takes one more
// request, and s_tready drops only while both stages are full and m_tready is low.
module json_structural_scanner
    import jss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_byte[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // event_kind[2:0], value_kind[5:3], nest_level[13:6],
                                   // bool_result[14], zero[15]
);

    // Input stage
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;

    // Result stage
    logic        out_valid_reg, out_valid_next;
    event_kind_t out_event_reg, out_event_next;
    value_kind_t out_kind_reg, out_kind_next;
    logic [7:0]  out_nest_reg, out_nest_next;
    logic        out_bool_reg, out_bool_next;

    // Scan state
    scan_mode_t  mode_reg, mode_next;
    logic [2:0]  lit_reg, lit_next;
    logic        esc_reg, esc_next;
    logic [7:0]  nest_reg, nest_next;
    value_kind_t cur_reg, cur_next;
    logic        latch_reg, latch_next;

    // Process the held byte whenever the result stage is free or draining
    logic advance;
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Next expected character of a true/false literal; zero when past the end
    function automatic logic [7:0] want_char(input logic is_t, input logic [2:0] idx);
        logic [7:0] w;
        w = CH_NUL;
        if (is_t)
        begin
            case (idx)
                3'd1:    w = CH_LOWER_R;
                3'd2:    w = CH_LOWER_U;
                3'd3:    w = CH_LOWER_E;
                default: w = CH_NUL;
            endcase
        end
        else
        begin
            case (idx)
                3'd1:    w = CH_LOWER_A;
                3'd2:    w = CH_LOWER_L;
                3'd3:    w = CH_LOWER_S;
                3'd4:    w = CH_LOWER_E;
                default: w = CH_NUL;
            endcase
        end
        return w;
    endfunction

    logic        b_digit, b_space, b_num_char, b_num_start;
    logic        run_between, number_end;
    event_kind_t ev, bw_ev;
    value_kind_t kind, bw_kind;
    logic        bres;
    logic        lit_is_t;
    logic [2:0]  lit_len, lit_plus;
    logic [7:0]  lit_want;

    assign b_digit     = (in_byte_reg >= CH_DIGIT_0) && (in_byte_reg <= CH_DIGIT_9);
    assign b_space     = (in_byte_reg == CH_SPACE) || (in_byte_reg == CH_NEWLINE)
                      || (in_byte_reg == CH_RETURN) || (in_byte_reg == CH_TAB);
    assign b_num_start = b_digit || (in_byte_reg == CH_MINUS) || (in_byte_reg == CH_PLUS);
    assign b_num_char  = b_num_start || (in_byte_reg == CH_POINT)
                      || (in_byte_reg == CH_LOWER_E) || (in_byte_reg == CH_UPPER_E);

    assign lit_is_t = (mode_reg == MODE_TRUE);
    assign lit_len  = lit_is_t ? TRUE_LEN : FALSE_LEN;
    assign lit_want = want_char(lit_is_t, lit_reg);
    assign lit_plus = lit_reg + 3'd1;

    always_comb
    begin
        mode_next   = mode_reg;
        lit_next    = lit_reg;
        esc_next    = esc_reg;
        nest_next   = nest_reg;
        cur_next    = cur_reg;
        latch_next  = latch_reg;
        ev          = EV_NONE;
        kind        = K_UNKNOWN;
        bres        = 1'b0;
        run_between = 1'b0;
        number_end  = 1'b0;
        bw_ev       = EV_NONE;
        bw_kind     = K_UNKNOWN;

        case (mode_reg)
            MODE_STRING:
            begin
                kind = K_STRING;
                if (in_byte_reg == CH_NUL)
                begin
                    // Document ended inside a string
                    ev        = EV_UNTERM;
                    mode_next = MODE_BETWEEN;
                    esc_next  = 1'b0;
                    cur_next  = K_UNKNOWN;
                end
                else if (esc_reg)
                begin
                    esc_next = 1'b0;
                end
                else if (in_byte_reg == CH_BACKSLASH)
                begin
                    esc_next = 1'b1;
                end
                else if (in_byte_reg == CH_QUOTE)
                begin
                    ev        = EV_END;
                    mode_next = MODE_BETWEEN;
                    cur_next  = K_UNKNOWN;
                end
            end
            MODE_TRUE, MODE_FALSE:
            begin
                kind = K_BOOL;
                if ((lit_want != CH_NUL) && ((in_byte_reg | CASE_FOLD) == lit_want))
                begin
                    lit_next = lit_plus;
                    if (lit_plus > lit_len)
                    begin
                        ev        = EV_END;
                        bres      = latch_reg;
                        mode_next = MODE_BETWEEN;
                        lit_next  = 3'd0;
                        cur_next  = K_UNKNOWN;
                    end
                end
                else
                begin
                    ev        = EV_BAD_BOOL;
                    mode_next = MODE_BETWEEN;
                    lit_next  = 3'd0;
                    cur_next  = K_UNKNOWN;
                end
            end
            MODE_NUMBER:
            begin
                if (b_num_char)
                begin
                    kind = K_NUMBER;
                end
                else
                begin
                    // Terminating byte is also scanned as between values
                    run_between = 1'b1;
                    number_end  = 1'b1;
                    mode_next   = MODE_BETWEEN;
                    cur_next    = K_UNKNOWN;
                end
            end
            default:
            begin
                run_between = 1'b1;
                mode_next   = MODE_BETWEEN;
            end
        endcase

        if (run_between)
        begin
            if ((in_byte_reg == CH_LBRACE) || (in_byte_reg == CH_LBRACKET))
            begin
                bw_kind = (in_byte_reg == CH_LBRACE) ? K_OBJECT : K_ARRAY;
                if (nest_reg >= DEPTH_CAP)
                begin
                    bw_ev    = EV_DEPTH;
                    cur_next = K_UNKNOWN;
                end
                else
                begin
                    bw_ev     = EV_START;
                    nest_next = nest_reg + 8'd1;
                    cur_next  = bw_kind;
                end
            end
            else if ((in_byte_reg == CH_RBRACE) || (in_byte_reg == CH_RBRACKET))
            begin
                bw_kind  = (in_byte_reg == CH_RBRACE) ? K_OBJECT : K_ARRAY;
                cur_next = K_UNKNOWN;
                if (nest_reg == 8'd0)
                begin
                    bw_ev = EV_DEPTH;
                end
                else
                begin
                    bw_ev     = EV_CLOSE;
                    nest_next = nest_reg - 8'd1;
                end
            end
            else if (in_byte_reg == CH_QUOTE)
            begin
                mode_next = MODE_STRING;
                esc_next  = 1'b0;
                cur_next  = K_STRING;
                bw_kind   = K_STRING;
                bw_ev     = EV_START;
            end
            else if ((in_byte_reg == CH_LOWER_T) || (in_byte_reg == CH_UPPER_T)
                  || (in_byte_reg == CH_LOWER_F) || (in_byte_reg == CH_UPPER_F))
            begin
                latch_next = (in_byte_reg == CH_LOWER_T) || (in_byte_reg == CH_UPPER_T);
                mode_next  = latch_next ? MODE_TRUE : MODE_FALSE;
                lit_next   = 3'd1;
                cur_next   = K_BOOL;
                bw_kind    = K_BOOL;
                bw_ev      = EV_START;
            end
            else if (b_num_start)
            begin
                mode_next = MODE_NUMBER;
                cur_next  = K_NUMBER;
                bw_kind   = K_NUMBER;
                bw_ev     = EV_START;
            end
            else
            begin
                // Separators and NUL leave the current kind alone
                if (!(b_space || (in_byte_reg == CH_COLON) || (in_byte_reg == CH_COMMA)
                      || (in_byte_reg == CH_NUL)))
                begin
                    cur_next = K_UNKNOWN;
                end
                bw_kind = cur_next;
                bw_ev   = EV_NONE;
            end

            // A number end reports the number unless its byte hit a depth error
            if (number_end)
            begin
                if (bw_ev == EV_DEPTH)
                begin
                    ev   = EV_DEPTH;
                    kind = bw_kind;
                end
                else
                begin
                    ev   = EV_END;
                    kind = K_NUMBER;
                end
            end
            else
            begin
                ev   = bw_ev;
                kind = bw_kind;
            end
        end
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        out_event_next = ev;
        out_kind_next  = kind;
        out_nest_next  = nest_next;
        out_bool_next  = bres;
    end

    // Control state and scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_BETWEEN;
            lit_reg       <= 3'd0;
            esc_reg       <= 1'b0;
            nest_reg      <= 8'd0;
            cur_reg       <= K_UNKNOWN;
            latch_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                mode_reg  <= mode_next;
                lit_reg   <= lit_next;
                esc_reg   <= esc_next;
                nest_reg  <= nest_next;
                cur_reg   <= cur_next;
                latch_reg <= latch_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
        end
        if (advance)
        begin
            out_event_reg <= out_event_next;
            out_kind_reg  <= out_kind_next;
            out_nest_reg  <= out_nest_next;
            out_bool_reg  <= out_bool_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_bool_reg, out_nest_reg, out_kind_reg, out_event_reg};

endmodule

// ===== hw/rtl/json_structural_scanner_checker.sv =====
// Port-level checks for json_structural_scanner, bound to the top level.
// Depends on jss_pkg.
module json_structural_scanner_checker
    import jss_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    logic       out_take;
    logic [7:0] prev_nest_reg;

    assign out_take = m_tvalid && m_tready;

    // Track depth of the last delivered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_nest_reg <= 8'd0;
        end
        else if (out_take)
        begin
            prev_nest_reg <= m_tdata[13:6];
        end
    end

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Drop input ready only behind a stalled output
    a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

    // Depth moves by at most one per byte
    a_depth_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_take |-> (m_tdata[13:6] == prev_nest_reg)
                  || (m_tdata[13:6] == prev_nest_reg + 8'd1)
                  || (m_tdata[13:6] == prev_nest_reg - 8'd1))
        else $error("depth jumped");

    // Close concerns a container
    a_close_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[2:0] == EV_CLOSE) |->
            (m_tdata[5:3] == K_OBJECT) || (m_tdata[5:3] == K_ARRAY))
        else $error("close without container kind");

    // Boolean result only on a boolean value end
    a_bool_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[14] |-> (m_tdata[2:0] == EV_END) && (m_tdata[5:3] == K_BOOL))
        else $error("boolean result outside boolean end");

endmodule

bind json_structural_scanner json_structural_scanner_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
